[src/csd_pkg.sv]
`default_nettype none

package csd_pkg;

  // Field widths
  localparam int DW          = 32;              // spin component, coupling, field
  localparam int PW          = 2 * DW;          // full product
  localparam int QSHIFT      = 16;              // Q16.16 fraction bits
  localparam int FW          = PW - QSHIFT;     // product after floor shift
  localparam int SW          = FW + 2;          // lane sum, three terms max
  localparam int AW          = 48;              // Overhauser accumulator
  localparam int IDXW        = 6;               // spin_index
  localparam int IN_TDATA_W  = 4 * DW;
  localparam int OUT_PAD_W   = 2;
  localparam int OUT_TDATA_W = IDXW + 3 * DW + OUT_PAD_W;

  localparam int MAX_BATH_DEF = 63;

  // in_tuser codes
  localparam logic ACT_CENTRAL = 1'b0;
  localparam logic ACT_BATH    = 1'b1;

  // Multiplier operand select
  localparam logic [2:0] MUL_NONE = 3'd0;
  localparam logic [2:0] MUL_X1   = 3'd1;  // S[i+1] * b[i+2]
  localparam logic [2:0] MUL_X2   = 3'd2;  // S[i+2] * b[i+1]
  localparam logic [2:0] MUL_JB   = 3'd3;  // J * b[i]
  localparam logic [2:0] MUL_JC   = 3'd4;  // J * c[i]
  localparam logic [2:0] MUL_A1   = 3'd5;  // a[i+1] * S[i+2]
  localparam logic [2:0] MUL_A2   = 3'd6;  // a[i+2] * S[i+1]
  localparam logic [2:0] MUL_HS   = 3'd7;  // field term

  // Accumulate stage ops
  localparam logic [2:0] ACC_NONE = 3'd0;
  localparam logic [2:0] ACC_LOAD = 3'd1;
  localparam logic [2:0] ACC_SUB  = 3'd2;
  localparam logic [2:0] ACC_HADD = 3'd3;  // + on x and z lanes, - on y lane
  localparam logic [2:0] ACC_OVH  = 3'd4;  // Overhauser update

  typedef struct packed {
    logic       take_central;
    logic       take_bath;
    logic [2:0] mul_sel;
    logic [2:0] acc_op;
    logic       latch_cv;
    logic       load_out;
    logic       out_last;
  } csd_cmd_t;

  typedef struct packed {
    logic out_free;
  } csd_stat_t;

endpackage

`default_nettype wire

[src/central_spin_derivative_top.sv]
// Central-spin equations of motion, right-hand side, Q16.16.
// Central-spin transaction: no result, block ready again next cycle.
// Bath transaction: steps X1, X2, JB, OVH, JC, JLD, BOUT (BOUT waits while the output
//   register is full), then the next transaction is taken. A last bath spin goes on through
//   A1, A2, HS, HADD, COUT to add the central result. Three lane multipliers set the pace.
// Reset (rst_n low, synchronous): central spin, Overhauser field, bath count, field = 0.
`default_nettype none

module central_spin_derivative_top #(
  parameter int MAX_BATH = csd_pkg::MAX_BATH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [csd_pkg::IN_TDATA_W-1:0]    in_tdata,  // comp_x, comp_y, comp_z, coupling
  input  logic                              in_tuser,  // action: 0 central, 1 bath
  input  logic                              in_tlast,  // last_bath
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [csd_pkg::OUT_TDATA_W-1:0]   out_tdata, // spin_index, rate_x, rate_y, rate_z, pad
  output logic                              out_tlast, // last (central result)
  // Config: z field, signed Q16.16
  input  logic                              cfg_we,
  input  logic [csd_pkg::DW-1:0]            cfg_wdata
);
  import csd_pkg::*;

  csd_cmd_t  cmd;
  csd_stat_t stat;

  // Controller sequences the steps of one transaction; the datapath holds
  // three multiplier lanes (x, y, z), the spin state and the output register.
  csd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .stat      (stat),
    .cmd       (cmd)
  );

  csd_datapath #(
    .MAX_BATH (MAX_BATH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Central result always carries index zero
  a_central_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[IDXW-1:0] == '0))
    else $error("central result with nonzero spin_index");

  // Bath result index is at least one
  a_bath_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[IDXW-1:0] != '0))
    else $error("bath result with zero spin_index");

  // A central-spin transaction never produces a result
  a_central_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == ACT_CENTRAL) && !out_tvalid) |=> !out_tvalid)
    else $error("result after central-spin transaction");

  // Results are loaded only while the input side is held off
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result loaded while idle");

endmodule

`default_nettype wire

[src/csd_datapath.sv]
`default_nettype none

module csd_datapath #(
  parameter int MAX_BATH = csd_pkg::MAX_BATH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  csd_pkg::csd_cmd_t                   cmd,
  output csd_pkg::csd_stat_t                  stat,
  input  logic [csd_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                cfg_we,
  input  logic [csd_pkg::DW-1:0]              cfg_wdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [csd_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tlast
);
  import csd_pkg::*;

  function automatic logic signed [DW-1:0] sat32(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    lo = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};
    if (v > hi) begin
      sat32 = {1'b0, {(DW-1){1'b1}}};
    end else if (v < lo) begin
      sat32 = {1'b1, {(DW-1){1'b0}}};
    end else begin
      sat32 = v[DW-1:0];
    end
  endfunction

  function automatic logic signed [AW-1:0] sat48(input logic signed [AW:0] v);
    if (v[AW] != v[AW-1]) begin
      sat48 = v[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      sat48 = v[AW-1:0];
    end
  endfunction

  logic signed [DW-1:0] s_r    [3];
  logic signed [DW-1:0] b_r    [3];
  logic signed [DW-1:0] cv_r   [3];
  logic signed [DW-1:0] a_val  [3];
  logic signed [DW-1:0] rate   [3];
  logic signed [AW-1:0] ovh_r  [3];
  logic signed [PW-1:0] prod_r [3];
  logic signed [SW-1:0] sum_r  [3];
  logic signed [DW-1:0] j_r;
  logic signed [DW-1:0] h_r;
  logic [IDXW-1:0]      cnt_r;

  logic                 out_valid_r;
  logic                 out_last_r;
  logic [IDXW-1:0]      out_idx_r;
  logic [DW-1:0]        out_rate_r [3];

  // Field register and bath counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r   <= '0;
      cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        h_r <= cfg_wdata;
      end
      if (cmd.take_central) begin
        cnt_r <= '0;
      end else if (cmd.take_bath && (cnt_r < IDXW'(MAX_BATH))) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_bath) begin
      j_r <= in_tdata[3*DW +: DW];
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    localparam int J1 = (g + 1) % 3;
    localparam int J2 = (g + 2) % 3;

    logic signed [DW-1:0] op_a;
    logic signed [DW-1:0] op_b;
    logic signed [FW-1:0] term;
    logic signed [SW-1:0] term_x;
    logic signed [AW:0]   ovh_sum;

    always_comb begin
      op_a = '0;
      op_b = '0;
      case (cmd.mul_sel)
        MUL_X1: begin op_a = s_r[J1];  op_b = b_r[J2]; end
        MUL_X2: begin op_a = s_r[J2];  op_b = b_r[J1]; end
        MUL_JB: begin op_a = j_r;      op_b = b_r[g];  end
        MUL_JC: begin op_a = j_r;      op_b = cv_r[g]; end
        MUL_A1: begin op_a = a_val[J1]; op_b = s_r[J2]; end
        MUL_A2: begin op_a = a_val[J2]; op_b = s_r[J1]; end
        MUL_HS: begin
          // x lane: H*S_y, y lane: H*S_x (subtracted later), z lane: none
          if (g == 0) begin
            op_a = h_r;
            op_b = s_r[1];
          end else if (g == 1) begin
            op_a = h_r;
            op_b = s_r[0];
          end
        end
        default: begin
          op_a = '0;
          op_b = '0;
        end
      endcase
    end

    always_ff @(posedge clk) begin
      prod_r[g] <= op_a * op_b;
    end

    // floor(p / 2^16)
    assign term    = prod_r[g][PW-1:QSHIFT];
    assign term_x  = SW'(term);
    assign ovh_sum = (AW+1)'(ovh_r[g]) + (AW+1)'(term);

    always_ff @(posedge clk) begin
      case (cmd.acc_op)
        ACC_LOAD: sum_r[g] <= term_x;
        ACC_SUB:  sum_r[g] <= sum_r[g] - term_x;
        ACC_HADD: sum_r[g] <= (g == 1) ? (sum_r[g] - term_x) : (sum_r[g] + term_x);
        default:  sum_r[g] <= sum_r[g];
      endcase
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_r[g]   <= '0;
        ovh_r[g] <= '0;
      end else if (cmd.take_central) begin
        s_r[g]   <= in_tdata[g*DW +: DW];
        ovh_r[g] <= '0;
      end else if (cmd.acc_op == ACC_OVH) begin
        ovh_r[g] <= sat48(ovh_sum);
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.take_bath) begin
        b_r[g] <= in_tdata[g*DW +: DW];
      end
      if (cmd.latch_cv) begin
        cv_r[g] <= sat32(sum_r[g]);
      end
    end

    assign a_val[g] = sat32(SW'(ovh_r[g]));
    assign rate[g]  = sat32(sum_r[g]);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_last_r    <= cmd.out_last;
      out_idx_r     <= cmd.out_last ? '0 : cnt_r;
      out_rate_r[0] <= rate[0];
      out_rate_r[1] <= rate[1];
      out_rate_r[2] <= rate[2];
    end
  end

  assign stat.out_free = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tlast     = out_last_r;
  assign out_tdata     = {{OUT_PAD_W{1'b0}}, out_rate_r[2], out_rate_r[1], out_rate_r[0],
                          out_idx_r};

endmodule

`default_nettype wire

[src/csd_ctrl.sv]
`default_nettype none

module csd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               in_tuser,
  input  logic               in_tlast,
  input  csd_pkg::csd_stat_t stat,
  output csd_pkg::csd_cmd_t  cmd
);
  import csd_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  localparam logic [3:0] STP_X1    = 4'd0;
  localparam logic [3:0] STP_X2    = 4'd1;
  localparam logic [3:0] STP_JB    = 4'd2;
  localparam logic [3:0] STP_OVH   = 4'd3;
  localparam logic [3:0] STP_JC    = 4'd4;
  localparam logic [3:0] STP_JLD   = 4'd5;
  localparam logic [3:0] STP_BOUT  = 4'd6;
  localparam logic [3:0] STP_A1    = 4'd7;
  localparam logic [3:0] STP_A2    = 4'd8;
  localparam logic [3:0] STP_HS    = 4'd9;
  localparam logic [3:0] STP_HADD  = 4'd10;
  localparam logic [3:0] STP_COUT  = 4'd11;

  logic       state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic       last_r, last_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    step_nxt  = step_r;
    last_nxt  = last_r;
    in_tready = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == ACT_CENTRAL) begin
            cmd.take_central = 1'b1;
          end else begin
            cmd.take_bath = 1'b1;
            last_nxt      = in_tlast;
            state_nxt     = ST_BUSY;
            step_nxt      = STP_X1;
          end
        end
      end
      ST_BUSY: begin
        step_nxt = step_r + 1'b1;
        case (step_r)
          STP_X1:  cmd.mul_sel = MUL_X1;
          STP_X2:  begin cmd.mul_sel = MUL_X2; cmd.acc_op = ACC_LOAD; end
          STP_JB:  begin cmd.mul_sel = MUL_JB; cmd.acc_op = ACC_SUB;  end
          STP_OVH: begin cmd.acc_op = ACC_OVH; cmd.latch_cv = 1'b1;   end
          STP_JC:  cmd.mul_sel = MUL_JC;
          STP_JLD: cmd.acc_op  = ACC_LOAD;
          STP_BOUT: begin
            if (stat.out_free) begin
              cmd.load_out = 1'b1;
              if (!last_r) begin
                state_nxt = ST_IDLE;
              end
            end else begin
              step_nxt = step_r;
            end
          end
          STP_A1:   cmd.mul_sel = MUL_A1;
          STP_A2:   begin cmd.mul_sel = MUL_A2; cmd.acc_op = ACC_LOAD; end
          STP_HS:   begin cmd.mul_sel = MUL_HS; cmd.acc_op = ACC_SUB;  end
          STP_HADD: cmd.acc_op = ACC_HADD;
          STP_COUT: begin
            if (stat.out_free) begin
              cmd.load_out = 1'b1;
              cmd.out_last = 1'b1;
              state_nxt    = ST_IDLE;
            end else begin
              step_nxt = step_r;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= STP_X1;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

`default_nettype wire

[bench/csd_checker.sv]
`default_nettype none

module csd_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  input  logic                                 in_tready,
  input  logic [csd_pkg::IN_TDATA_W-1:0]       in_tdata,   // comp_x, comp_y, comp_z, coupling
  input  logic                                 in_tuser,   // action
  input  logic                                 in_tlast,   // last_bath
  input  logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic [csd_pkg::OUT_TDATA_W-1:0]      out_tdata,  // spin_index, rate_x/y/z, pad
  input  logic                                 out_tlast,  // last
  input  logic                                 cfg_we,
  input  logic [csd_pkg::DW-1:0]               cfg_wdata,
  output int                                   mismatches_o,
  output int                                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import csd_pkg::*;

  localparam longint SAT32_HI = 64'sd2147483647;
  localparam longint SAT32_LO = -64'sd2147483648;
  localparam longint SAT48_HI = 64'sd140737488355327;
  localparam longint SAT48_LO = -64'sd140737488355328;

  typedef struct packed {
    logic [IDXW-1:0] idx;
    logic [DW-1:0]   rx;
    logic [DW-1:0]   ry;
    logic [DW-1:0]   rz;
    logic            last;
  } deriv_t;

  deriv_t due_q[$];

  // Shadow of the block state
  longint      spin_s[3];
  longint      ovh_acc[3];
  int unsigned bath_n;
  longint      field_h;
  int          n_bad;

  function automatic longint sx(input logic [DW-1:0] v);
    return longint'($signed(v));
  endfunction

  // floor(a*b / 2^16)
  function automatic longint fl_mul(input longint a, input longint b);
    return (a * b) >>> QSHIFT;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [DW-1:0] sat32(input longint v);
    longint t;
    t = clip(v, SAT32_LO, SAT32_HI);
    return t[DW-1:0];
  endfunction

  task automatic log_mismatch(input string msg);
    n_bad++;
    $display("%0t csd_checker: %s", $time, msg);
  endtask

  task automatic advance_spins(input logic act, input logic [IN_TDATA_W-1:0] d,
                               input logic lst);
    longint b[3];
    longint c[3];
    longint a[3];
    longint j;
    deriv_t r;
    b[0] = sx(d[DW-1:0]);
    b[1] = sx(d[2*DW-1:DW]);
    b[2] = sx(d[3*DW-1:2*DW]);
    j    = sx(d[4*DW-1:3*DW]);
    if (act == ACT_CENTRAL) begin
      for (int i = 0; i < 3; i++) begin
        spin_s[i]  = b[i];
        ovh_acc[i] = 0;
      end
      bath_n = 0;
    end else begin
      if (bath_n < MAX_BATH_DEF) bath_n++;
      c[0] = clip(fl_mul(spin_s[1], b[2]) - fl_mul(spin_s[2], b[1]), SAT32_LO, SAT32_HI);
      c[1] = clip(fl_mul(spin_s[2], b[0]) - fl_mul(spin_s[0], b[2]), SAT32_LO, SAT32_HI);
      c[2] = clip(fl_mul(spin_s[0], b[1]) - fl_mul(spin_s[1], b[0]), SAT32_LO, SAT32_HI);
      r.idx  = bath_n[IDXW-1:0];
      r.rx   = sat32(fl_mul(j, c[0]));
      r.ry   = sat32(fl_mul(j, c[1]));
      r.rz   = sat32(fl_mul(j, c[2]));
      r.last = 1'b0;
      due_q.push_back(r);
      for (int i = 0; i < 3; i++)
        ovh_acc[i] = clip(ovh_acc[i] + fl_mul(j, b[i]), SAT48_LO, SAT48_HI);
      if (lst) begin
        for (int i = 0; i < 3; i++) a[i] = clip(ovh_acc[i], SAT32_LO, SAT32_HI);
        r.idx  = '0;
        r.rx   = sat32(fl_mul(a[1], spin_s[2]) - fl_mul(a[2], spin_s[1])
                       + fl_mul(field_h, spin_s[1]));
        r.ry   = sat32(fl_mul(a[2], spin_s[0]) - fl_mul(a[0], spin_s[2])
                       - fl_mul(field_h, spin_s[0]));
        r.rz   = sat32(fl_mul(a[0], spin_s[1]) - fl_mul(a[1], spin_s[0]));
        r.last = 1'b1;
        due_q.push_back(r);
      end
    end
  endtask

  task automatic check_result();
    deriv_t want;
    deriv_t got;
    got.idx  = out_tdata[IDXW-1:0];
    got.rx   = out_tdata[IDXW+DW-1:IDXW];
    got.ry   = out_tdata[IDXW+2*DW-1:IDXW+DW];
    got.rz   = out_tdata[IDXW+3*DW-1:IDXW+2*DW];
    got.last = out_tlast;
    if (out_tdata[OUT_TDATA_W-1:OUT_TDATA_W-OUT_PAD_W] != '0)
      log_mismatch("nonzero pad bits in out_tdata");
    if (due_q.size() == 0) begin
      log_mismatch($sformatf("result with nothing predicted: idx %0d last %0b",
                             got.idx, got.last));
    end else begin
      want = due_q.pop_front();
      if (got.idx != want.idx)
        log_mismatch($sformatf("spin_index got %0d want %0d", got.idx, want.idx));
      if (got.rx != want.rx)
        log_mismatch($sformatf("rate_x got %h want %h (idx %0d)", got.rx, want.rx, want.idx));
      if (got.ry != want.ry)
        log_mismatch($sformatf("rate_y got %h want %h (idx %0d)", got.ry, want.ry, want.idx));
      if (got.rz != want.rz)
        log_mismatch($sformatf("rate_z got %h want %h (idx %0d)", got.rz, want.rz, want.idx));
      if (got.last != want.last)
        log_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
    end
  endtask

  initial begin
    n_bad        = 0;
    bath_n       = 0;
    field_h      = 0;
    mismatches_o = 0;
    pending_o    = 0;
    for (int i = 0; i < 3; i++) begin
      spin_s[i]  = 0;
      ovh_acc[i] = 0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        spin_s[i]  = 0;
        ovh_acc[i] = 0;
      end
      bath_n  = 0;
      field_h = 0;
      due_q.delete();
    end else begin
      if (cfg_we) field_h = sx(cfg_wdata);
      if (in_tvalid && in_tready) advance_spins(in_tuser, in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_result();
    end
    pending_o    <= due_q.size();
    mismatches_o <= n_bad;
  end

endmodule

`default_nettype wire

[bench/central_spin_derivative_top_tb.sv]
`default_nettype none

module central_spin_derivative_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csd_pkg::*;

  // Handy Q16.16 words
  localparam logic [DW-1:0] Q_ONE  = 32'h0001_0000;
  localparam logic [DW-1:0] Q_MONE = 32'hFFFF_0000;
  localparam logic [DW-1:0] W_MAX  = 32'h7FFF_FFFF;
  localparam logic [DW-1:0] W_MIN  = 32'h8000_0000;
  localparam logic [DW-1:0] W_M1   = 32'hFFFF_FFFF;

  localparam int HOLD_CYCLES   = 400;       // long receiver hold-off
  localparam int SETTLE_CYCLES = 24;        // outlasts the block's longest unstalled transaction
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PHASE_ITEMS   = 290;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_we;
  logic [DW-1:0]          cfg_wdata;

  int fail_count;
  int pending;
  int cycles;
  int sent;
  int tx_left;
  int tx_pct;
  bit calm;       // no idling on either side in the closing phase
  bit hold_req;   // asks the receiver for one long hold-off

  central_spin_derivative_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // Watches both streams and the field register, predicts and compares
  csd_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .mismatches_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("central_spin_derivative_top regression: fail");
      $finish;
    end
  end

  // Idle density for a stretch: none, light or heavy
  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 8;
      default: return 30;
    endcase
  endfunction

  // Receiver: random stall bursts, stretches without stalls, one long hold-off
  initial begin : sink
    int rx_left;
    int rx_pct;
    rx_left = 0;
    rx_pct  = 0;
    out_tready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (rx_left == 0) begin
        rx_left = $urandom_range(20, 200);
        rx_pct  = pick_idle_pct();
      end
      rx_left--;
      if (hold_req) begin
        // hold off while the sender keeps offering, so the block backs up
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 99) < rx_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Random Q16.16 word: extremes, zero, small magnitudes and full range
  function automatic logic [DW-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return W_MAX;
      1:       return W_MIN;
      2:       return '0;
      3, 4:    return $urandom_range(0, 32'h8_0000) - 32'h4_0000;  // about +-4.0
      default: return $urandom;
    endcase
  endfunction

  // One input transaction; returns after the accepting edge, valid left high or, after an idle gap, low
  task automatic send(input logic act, input logic [DW-1:0] x, input logic [DW-1:0] y,
                      input logic [DW-1:0] z, input logic [DW-1:0] j, input logic lst);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {j, z, y, x};
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    if (tx_left == 0) begin
      tx_left = $urandom_range(20, 200);
      tx_pct  = pick_idle_pct();
    end
    tx_left--;
    if (!calm && $urandom_range(0, 99) < tx_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Sender stops until every predicted result is out and the block has settled
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_field(input logic [DW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly complete sets (central, then baths, last marked); some noise
  task automatic random_group();
    int n;
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      // stray bath spin: counter and field carry on
      send(ACT_BATH, rand_word(), rand_word(), rand_word(), rand_word(), 1'($urandom));
    end else if (r < 14) begin
      // set cut short, never marked last
      send(ACT_CENTRAL, rand_word(), rand_word(), rand_word(), $urandom, 1'($urandom));
      n = $urandom_range(1, 4);
      for (int k = 0; k < n; k++)
        send(ACT_BATH, rand_word(), rand_word(), rand_word(), rand_word(), 1'b0);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 85)      n = $urandom_range(1, 8);
      else if (r < 97) n = $urandom_range(9, 30);
      else             n = $urandom_range(60, 70);
      send(ACT_CENTRAL, rand_word(), rand_word(), rand_word(), $urandom, 1'($urandom));
      for (int k = 0; k < n; k++)
        send(ACT_BATH, rand_word(), rand_word(), rand_word(), rand_word(), k == n - 1);
    end
  endtask

  initial begin : stimulus
    int            target;
    logic [DW-1:0] h;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= ACT_CENTRAL;
    in_tlast  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    calm     = 1'b0;
    hold_req = 1'b0;
    sent     = 0;
    tx_left  = 0;
    tx_pct   = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, field at its positive extreme
    set_field(W_MAX);
    // bath spin before any central spin: S is still zero
    send(ACT_BATH, Q_ONE, 32'hFFFE_0000, 32'h0003_0000, Q_ONE, 1'b1);
    // central spin at extremes; its last flag and coupling must not matter
    send(ACT_CENTRAL, W_MAX, W_MIN, W_MAX, 32'h1234_5678, 1'b1);
    send(ACT_BATH, W_MIN, W_MAX, W_MIN, W_MIN, 1'b0);
    // large positive J*b terms push the Overhauser field into 48-bit saturation
    send(ACT_BATH, W_MIN, W_MIN, W_MIN, W_MIN, 1'b0);
    send(ACT_BATH, W_MIN, W_MIN, W_MIN, W_MIN, 1'b0);
    send(ACT_BATH, W_MAX, W_MAX, W_MAX, W_MAX, 1'b1);
    // bath after the end of a set with no new central spin
    send(ACT_BATH, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b1);
    // unit vectors
    send(ACT_CENTRAL, Q_ONE, '0, '0, '0, 1'b0);
    send(ACT_BATH, '0, Q_ONE, '0, Q_ONE, 1'b0);
    send(ACT_BATH, '0, '0, Q_ONE, Q_MONE, 1'b1);
    // zero central spin, nonzero field
    send(ACT_CENTRAL, '0, '0, '0, W_M1, 1'b0);
    send(ACT_BATH, W_MAX, W_MIN, '0, W_MAX, 1'b1);
    // smallest magnitudes: floor of tiny negative products
    send(ACT_CENTRAL, W_M1, 32'h0000_0001, W_M1, '0, 1'b0);
    send(ACT_BATH, 32'h0000_0001, W_M1, 32'h0000_0001, W_M1, 1'b1);
    // negative Overhauser saturation
    send(ACT_CENTRAL, W_MIN, W_MIN, W_MIN, '0, 1'b0);
    send(ACT_BATH, W_MAX, W_MIN, W_MAX, W_MIN, 1'b0);
    send(ACT_BATH, W_MAX, W_MIN, W_MAX, W_MIN, 1'b0);
    send(ACT_BATH, W_MAX, W_MIN, W_MAX, W_MIN, 1'b0);
    send(ACT_BATH, '0, '0, '0, '0, 1'b1);
    // more bath spins than the counter holds: index sticks at its maximum
    send(ACT_CENTRAL, rand_word(), rand_word(), rand_word(), '0, 1'b0);
    for (int k = 0; k < 70; k++)
      send(ACT_BATH, rand_word(), rand_word(), rand_word(), rand_word(), k == 69);
    drain();

    // Random phases, each with its own field value
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       h = W_MIN;
        1:       h = '0;
        2:       h = $urandom;
        3:       h = Q_ONE;
        4:       h = Q_MONE;
        default: h = $urandom_range(0, 32'h8_0000) - 32'h4_0000;
      endcase
      set_field(h);
      if (ph == 2) hold_req = 1'b1;   // receiver backs up the block here
      if (ph == 5) calm = 1'b1;       // closing phase runs flat out
      target = sent + PHASE_ITEMS;
      while (sent < target) random_group();
      drain();
    end

    // drain() above already waited out every prediction and the block's latency
    if (fail_count == 0) begin
      $display("central_spin_derivative_top regression: pass");
    end else begin
      $display("central_spin_derivative_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
src/csd_pkg.sv
src/csd_datapath.sv
src/csd_ctrl.sv
src/central_spin_derivative_top.sv
bench/csd_checker.sv
bench/central_spin_derivative_top_tb.sv
